### design/hybrid_gshare_local_branch_predictor_defines.svh
// Assertion macros shared by the branch predictor RTL.
// Included by files that carry concurrent checks.
`ifndef HYBRID_GSHARE_LOCAL_BRANCH_PREDICTOR_DEFINES_SVH
`define HYBRID_GSHARE_LOCAL_BRANCH_PREDICTOR_DEFINES_SVH

// Implication checked every clock, muted during reset.
`define HGL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted during reset.
`define HGL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/hgl_pkg.sv
// Shared types and constants for the hybrid branch predictor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hgl_pkg;
  localparam int HISTORY_BITS_DEF  = 10;
  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int COUNTER_WIDTH_DEF = 8;
  localparam logic [3:0] COUNTER_BITS_RESET = 4'd2;

  typedef enum logic [1:0] {
    PRED_NOT_TAKEN = 2'd0,
    PRED_TAKEN     = 2'd1,
    PRED_NONE      = 2'd2
  } pred_t;
endpackage
`default_nettype wire

### design/hgl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hgl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/hybrid_gshare_local_branch_predictor.sv
// Hybrid gshare / local-history branch predictor, top level.
// Depends on hgl_pkg, hgl_ram and the assertion macro header.
// Pipeline: history read, counter read, judge into the output register.
// Throughput: one branch per cycle; same-entry hazards are resolved by forwarding;
// a waiting result holds the whole pipeline and in_ready.
// Reset: synchronous, clears the pipeline and accuracy counters, then sweeps every row
// of the three tables clear while in_ready stays low.
`timescale 1ns / 1ps
`default_nettype none
`include "hybrid_gshare_local_branch_predictor_defines.svh"
module hybrid_gshare_local_branch_predictor
  import hgl_pkg::*;
#(
  parameter int HISTORY_BITS  = HISTORY_BITS_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] branch_address,
  input  wire logic        taken,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       final_prediction,
  output logic [1:0]       global_prediction,
  output logic [1:0]       local_prediction,
  output logic             was_correct,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int HW = HISTORY_BITS;
  localparam int CW = COUNTER_WIDTH;
  localparam int AW = (IW < HW) ? IW : HW;

  typedef logic [HW-1:0] hist_t;
  typedef logic [IW-1:0] idx_t;
  typedef logic [CW-1:0] ctr_t;

  // ---------------- config ----------------
  logic [3:0] counter_bits;
  ctr_t       maxv;
  ctr_t       lo_th;
  logic [CW:0] hi_th;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_bits <= COUNTER_BITS_RESET;
    end else if (cfg_valid) begin
      counter_bits <= cfg_data;
    end
  end
  always_comb begin
    logic [4:0] b;
    b = {1'b0, counter_bits};
    if (b < 5'd1) b = 5'd1;
    if (b > 5'(CW)) b = 5'(CW);
    maxv  = ctr_t'(({{CW{1'b0}}, 1'b1} << b) - 1'b1);
    lo_th = maxv >> 1;
    hi_th = {1'b0, lo_th} + 1'b1;
  end

  // ---------------- clear sweep ----------------
  logic        clearing;
  logic [IW:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (IW+1)'(TABLE_ENTRIES - 1)) clearing <= 1'b0;
    end
  end

  // ---------------- pipeline control ----------------
  // s0: local history read issued; s1: counters read issued; s2: judge/train; out reg.
  logic s1_v, s2_v;
  logic stall;
  assign stall    = out_valid && !out_ready;
  assign in_ready = !clearing && !stall;
  logic acc;
  assign acc = in_valid && in_ready;

  hist_t gh;
  logic  s1_t, s2_t;
  idx_t  s1_li;
  hist_t s1_br, s1_gh;
  idx_t  s2_gi, s2_pi;

  // local history table, with write from s1; the read stays on the s1 row while stalled
  hist_t lh_rdata, lh_wdata;
  idx_t  lh_waddr;
  logic  lh_we;
  idx_t  in_li, lh_raddr;
  assign in_li    = idx_t'(branch_address[AW+1:2]);
  assign lh_raddr = stall ? s1_li : in_li;
  hgl_ram #(.WIDTH(HW), .DEPTH(TABLE_ENTRIES)) u_lht (
    .clk(clk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
    .raddr(lh_raddr), .rdata(lh_rdata)
  );

  // forwarding for the local history: pending s1 write to the same row
  logic  lh_fw_v;
  hist_t lh_fw_d;
  hist_t s1_lh;
  always_ff @(posedge clk) begin
    lh_fw_v <= lh_we && (lh_waddr == lh_raddr);
    lh_fw_d <= lh_wdata;
  end
  assign s1_lh    = lh_fw_v ? lh_fw_d : lh_rdata;
  assign lh_we    = clearing || (s1_v && !stall);
  assign lh_waddr = clearing ? clr_cnt[IW-1:0] : s1_li;
  assign lh_wdata = clearing ? '0 : {s1_lh[HW-2:0], s1_t};

  idx_t s1_gi, s1_pi;
  assign s1_gi = idx_t'(s1_br ^ s1_gh);
  assign s1_pi = idx_t'(s1_lh);

  // stage 0 -> 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      gh   <= '0;
    end else if (!stall) begin
      s1_v <= acc;
      if (acc) gh <= {gh[HW-2:0], taken};
    end
  end
  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_t  <= taken;
      s1_li <= in_li;
      s1_br <= hist_t'(branch_address[AW+1:2]);
      s1_gh <= gh;
    end
  end

  // pattern counter tables, written from s2; reads stay on the s2 rows while stalled
  ctr_t gc_rdata, lc_rdata, gc_wdata, lc_wdata;
  logic c_we;
  idx_t gc_waddr, lc_waddr;
  idx_t gc_raddr, lc_raddr;
  assign gc_raddr = stall ? s2_gi : s1_gi;
  assign lc_raddr = stall ? s2_pi : s1_pi;
  hgl_ram #(.WIDTH(CW), .DEPTH(TABLE_ENTRIES)) u_gct (
    .clk(clk), .we(c_we), .waddr(gc_waddr), .wdata(gc_wdata),
    .raddr(gc_raddr), .rdata(gc_rdata)
  );
  hgl_ram #(.WIDTH(CW), .DEPTH(TABLE_ENTRIES)) u_lct (
    .clk(clk), .we(c_we), .waddr(lc_waddr), .wdata(lc_wdata),
    .raddr(lc_raddr), .rdata(lc_rdata)
  );

  // forwarding for counters: an s2 write landing on the row being read
  logic gc_fw_v, lc_fw_v;
  ctr_t gc_fw_d, lc_fw_d;
  always_ff @(posedge clk) begin
    gc_fw_v <= c_we && (gc_waddr == gc_raddr);
    lc_fw_v <= c_we && (lc_waddr == lc_raddr);
    gc_fw_d <= gc_wdata;
    lc_fw_d <= lc_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (!stall) begin
      s2_v <= s1_v;
    end
  end
  always_ff @(posedge clk) begin
    if (!stall) begin
      s2_t  <= s1_t;
      s2_gi <= s1_gi;
      s2_pi <= s1_pi;
    end
  end

  // stage 2: judge, select, train
  ctr_t  gc, lc;
  pred_t pg, pl, fin, outcome;
  logic [31:0] gcc, lcc;
  assign gc = gc_fw_v ? gc_fw_d : gc_rdata;
  assign lc = lc_fw_v ? lc_fw_d : lc_rdata;
  assign outcome = s2_t ? PRED_TAKEN : PRED_NOT_TAKEN;

  function automatic pred_t judge(ctr_t c, ctr_t mx, ctr_t lo, logic [CW:0] hi);
    if (c <= mx && {1'b0, c} > hi) return PRED_TAKEN;
    if (c < lo) return PRED_NOT_TAKEN;
    return PRED_NONE;
  endfunction

  function automatic ctr_t train(ctr_t c, logic t, ctr_t mx);
    if (t) return (c < mx) ? c + 1'b1 : mx;
    return (c != '0) ? c - 1'b1 : '0;
  endfunction

  always_comb begin
    pg = judge(gc, maxv, lo_th, hi_th);
    pl = judge(lc, maxv, lo_th, hi_th);
    if (pg == pl) fin = pg;
    else if (pg == PRED_NONE) fin = pl;
    else if (pl == PRED_NONE) fin = pg;
    else fin = (lcc < gcc) ? pg : pl;
  end

  logic s2_go;
  assign s2_go    = s2_v && !stall;
  assign c_we     = clearing || s2_go;
  assign gc_waddr = clearing ? clr_cnt[IW-1:0] : s2_gi;
  assign lc_waddr = clearing ? clr_cnt[IW-1:0] : s2_pi;
  assign gc_wdata = clearing ? '0 : train(gc, s2_t, maxv);
  assign lc_wdata = clearing ? '0 : train(lc, s2_t, maxv);

  // accuracy counters, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      gcc <= '0;
      lcc <= '0;
    end else if (s2_go) begin
      if (pg == outcome && gcc != '1) gcc <= gcc + 1'b1;
      if (pl == outcome && lcc != '1) lcc <= lcc + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall) begin
      out_valid <= s2_v;
    end
  end
  always_ff @(posedge clk) begin
    if (s2_go) begin
      final_prediction  <= fin;
      global_prediction <= pg;
      local_prediction  <= pl;
      was_correct       <= (fin == outcome);
    end
  end

  // checks
  `HGL_ASSERT_IMPL(a_no_in_clear, clearing, !in_ready, "input taken during clear sweep")
  `HGL_ASSERT_IMPL(a_no_res_clear, clearing, !s1_v && !s2_v, "item in flight during clear")
  `HGL_ASSERT_NEXT(a_hold_out, out_valid && !out_ready, out_valid && $stable(final_prediction),
                   "result dropped under stall")
  `HGL_ASSERT_IMPL(a_correct_known, out_valid && was_correct,
                   final_prediction != PRED_NONE, "correct flag on no prediction")
endmodule
`default_nettype wire
